[rtl/core/dcc_pkg.sv]
`timescale 1ns / 1ps
package dcc_pkg;

  localparam int Channels    = 64;
  localparam int MaxTaps     = 4;
  localparam int HistPerCh   = MaxTaps - 1;
  localparam int SampleWidth = 16;
  localparam int ChW         = $clog2(Channels);
  localparam int TapW        = $clog2(MaxTaps);
  localparam int KW          = 3;

  localparam logic [2:0] KIND_SAMPLE   = 3'd0;
  localparam logic [2:0] KIND_WEIGHT   = 3'd1;
  localparam logic [2:0] KIND_BIAS     = 3'd2;
  localparam logic [2:0] KIND_HIST_WR  = 3'd3;
  localparam logic [2:0] KIND_HIST_RD  = 3'd4;

  localparam logic [1:0] CFG_ACT_EN = 2'd0;
  localparam logic [1:0] CFG_TAPS   = 2'd1;

  localparam logic RESULT_CONV = 1'b0;
  localparam logic RESULT_HIST = 1'b1;

  typedef struct packed {
    logic [2:0]        kind;
    logic [ChW-1:0]    channel;
    logic [TapW-1:0]   tap;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] result_value;
    logic               result_kind;
    logic               saturated;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic          load;
    logic          rd;
    logic          mul;
    logic          sum;
    logic          act1;
    logic          act2;
    logic          conv_ld;
    logic          hist_ld;
    logic [1:0]    idx;
    logic          last;
    logic [KW-1:0] k;
  } dcc_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
  } dcc_status_t;

  function automatic logic [15:0] sig_lut(input logic [4:0] i);
    logic [15:0] r;
    case (i)
      5'd0:    r = 16'd16384;
      5'd1:    r = 16'd20397;
      5'd2:    r = 16'd23955;
      5'd3:    r = 16'd26790;
      5'd4:    r = 16'd28862;
      5'd5:    r = 16'd30282;
      5'd6:    r = 16'd31214;
      5'd7:    r = 16'd31807;
      5'd8:    r = 16'd32179;
      5'd9:    r = 16'd32408;
      5'd10:   r = 16'd32549;
      5'd11:   r = 16'd32635;
      5'd12:   r = 16'd32687;
      5'd13:   r = 16'd32719;
      5'd14:   r = 16'd32738;
      5'd15:   r = 16'd32750;
      5'd16:   r = 16'd32757;
      default: r = 16'd32757;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/dcc_ctrl.sv]
`timescale 1ns / 1ps
module dcc_ctrl import dcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i,
  input  dcc_status_t status_i,
  output dcc_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL, S_SUM, S_ACT1, S_ACT2, S_FIN, S_HLD, S_OUT
  } state_e;

  state_e        state_q;
  logic          act_en_q;
  logic [2:0]    taps_q;
  logic [1:0]    idx_q;
  logic          hist_q;
  logic [KW-1:0] k;
  logic [1:0]    n;

  always_comb begin
    if (taps_q == 3'd0) begin
      k = 3'd1;
    end else if (taps_q > 3'(MaxTaps)) begin
      k = 3'(MaxTaps);
    end else begin
      k = taps_q;
    end
  end
  assign n = 2'(k - 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      act_en_q <= 1'b0;
      taps_q   <= 3'd4;
      idx_q    <= 2'd0;
      hist_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_ACT_EN) begin
          act_en_q <= cfg_data_i[0];
        end else if (cfg_index_i == CFG_TAPS) begin
          taps_q <= cfg_data_i;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          idx_q  <= 2'd0;
          hist_q <= 1'b0;
          if (status_i.kind == KIND_SAMPLE) begin
            state_q <= S_MUL;
          end else if (status_i.kind == KIND_HIST_RD && n != 2'd0) begin
            hist_q  <= 1'b1;
            state_q <= S_HLD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_MUL: state_q <= S_SUM;
        S_SUM: state_q <= act_en_q ? S_ACT1 : S_FIN;
        S_ACT1: state_q <= S_ACT2;
        S_ACT2: state_q <= S_FIN;
        S_FIN: state_q <= S_OUT;
        S_HLD: state_q <= S_OUT;
        S_OUT: begin
          if (!out_stall_i) begin
            if (hist_q && (idx_q + 2'd1) != n) begin
              idx_q   <= idx_q + 2'd1;
              state_q <= S_HLD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    cmd_o         = '0;
    cmd_o.k       = k;
    cmd_o.idx     = idx_q;
    cmd_o.last    = (idx_q + 2'd1) == n;
    cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.rd      = (state_q == S_RD);
    cmd_o.mul     = (state_q == S_MUL);
    cmd_o.sum     = (state_q == S_SUM);
    cmd_o.act1    = (state_q == S_ACT1);
    cmd_o.act2    = (state_q == S_ACT2);
    cmd_o.conv_ld = (state_q == S_FIN);
    cmd_o.hist_ld = (state_q == S_HLD);
  end

endmodule

[rtl/core/dcc_datapath.sv]
`timescale 1ns / 1ps
module dcc_datapath import dcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_item_i,
  input  dcc_cmd_t    cmd_i,
  output dcc_status_t status_o,
  output out_item_t   out_item_o
);

  in_item_t req_q;

  logic signed [15:0] w_rd_q [MaxTaps];
  logic signed [15:0] h_rd_q [HistPerCh];
  logic               h_vld_q [HistPerCh];
  logic signed [15:0] h_eff [MaxTaps];
  logic signed [15:0] h_new [HistPerCh];
  logic               h_we [HistPerCh];

  logic signed [15:0] b_mem [Channels];
  logic [Channels-1:0] b_vld_q;
  logic signed [15:0] b_rd_q;
  logic               b_rdv_q;

  logic signed [31:0] p_q [MaxTaps];
  logic signed [15:0] bias_q;
  logic signed [20:0] y_q;
  logic signed [34:0] acc;
  logic signed [34:0] acc_r;
  logic signed [15:0] x [MaxTaps];

  logic [14:0]        a;
  logic [3:0]         t;
  logic [10:0]        frac;
  logic [15:0]        s_base;
  logic [15:0]        s_diff;
  logic [26:0]        step;
  logic [15:0]        s_q;
  logic               neg_q;
  logic [16:0]        sig;
  logic signed [37:0] prod;
  logic signed [37:0] prod_r;
  out_item_t          out_q;

  assign status_o.kind = req_q.kind;
  assign out_item_o    = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_item_i;
    end
  end

  for (genvar w = 0; w < MaxTaps; w++) begin : g_wlane
    logic signed [15:0] mem [Channels];
    always_ff @(posedge clk_i) begin
      if (cmd_i.rd && req_q.kind == KIND_WEIGHT && req_q.tap == TapW'(w)) begin
        mem[req_q.channel] <= req_q.value;
      end
      if (cmd_i.rd) begin
        w_rd_q[w] <= mem[req_q.channel];
      end
    end
  end

  for (genvar h = 0; h < HistPerCh; h++) begin : g_hlane
    logic signed [15:0] mem [Channels];
    logic [Channels-1:0] vld_q;
    logic               wr_en;
    logic signed [15:0] wr_val;

    always_comb begin
      wr_en  = 1'b0;
      wr_val = req_q.value;
      if (cmd_i.rd && req_q.kind == KIND_HIST_WR && req_q.tap == TapW'(h)) begin
        wr_en = 1'b1;
      end else if (cmd_i.mul && h_we[h]) begin
        wr_en  = 1'b1;
        wr_val = h_new[h];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= '0;
      end else if (wr_en) begin
        vld_q[req_q.channel] <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        mem[req_q.channel] <= wr_val;
      end
      if (cmd_i.rd) begin
        h_rd_q[h]  <= mem[req_q.channel];
        h_vld_q[h] <= vld_q[req_q.channel];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= '0;
    end else if (cmd_i.rd && req_q.kind == KIND_BIAS) begin
      b_vld_q[req_q.channel] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd && req_q.kind == KIND_BIAS) begin
      b_mem[req_q.channel] <= req_q.value;
    end
    if (cmd_i.rd) begin
      b_rd_q  <= b_mem[req_q.channel];
      b_rdv_q <= b_vld_q[req_q.channel];
    end
  end

  always_comb begin
    for (int j = 0; j < HistPerCh; j++) begin
      h_eff[j] = h_vld_q[j] ? h_rd_q[j] : 16'sd0;
    end
    h_eff[MaxTaps-1] = '0;
    for (int j = 0; j < MaxTaps; j++) begin
      if (KW'(j + 1) < cmd_i.k) begin
        x[j] = h_eff[j];
      end else if (KW'(j + 1) == cmd_i.k) begin
        x[j] = req_q.value;
      end else begin
        x[j] = '0;
      end
    end
    for (int h = 0; h < HistPerCh; h++) begin
      h_we[h]  = KW'(h + 2) <= cmd_i.k;
      h_new[h] = (KW'(h + 2) < cmd_i.k) ? h_eff[h + 1] : req_q.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      for (int j = 0; j < MaxTaps; j++) begin
        if (KW'(j + 1) <= cmd_i.k) begin
          p_q[j] <= x[j] * w_rd_q[j];
        end else begin
          p_q[j] <= '0;
        end
      end
      bias_q <= b_rdv_q ? b_rd_q : 16'sd0;
    end
  end

  always_comb begin
    acc = {{5{bias_q[15]}}, bias_q, 14'd0};
    for (int j = 0; j < MaxTaps; j++) begin
      acc = acc + 35'(p_q[j]);
    end
    acc_r = (acc + 35'sd8192) >>> 14;
  end

  always_comb begin
    a      = y_q[20] ? 15'(-y_q) : y_q[14:0];
    t      = a[14:11];
    frac   = a[10:0];
    s_base = sig_lut({1'b0, t});
    s_diff = sig_lut(5'({1'b0, t}) + 5'd1) - s_base;
    step   = (27'(s_diff) * 27'(frac) + 27'd1024) >> 11;
    sig    = neg_q ? (17'd32768 - 17'(s_q)) : 17'(s_q);
    prod   = 38'(y_q) * $signed({1'b0, sig}) + 38'sd16384;
    prod_r = prod >>> 15;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      y_q <= acc_r[20:0];
    end else if (cmd_i.act1) begin
      s_q   <= s_base + step[15:0];
      neg_q <= y_q[20];
    end else if (cmd_i.act2) begin
      if (y_q >= 21'sd32768) begin
        y_q <= y_q;
      end else if (y_q <= -21'sd32768) begin
        y_q <= '0;
      end else begin
        y_q <= prod_r[20:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.conv_ld) begin
      out_q.result_kind <= RESULT_CONV;
      out_q.last        <= 1'b1;
      if (y_q > 21'sd32767) begin
        out_q.result_value <= 16'sh7fff;
        out_q.saturated    <= 1'b1;
      end else if (y_q < -21'sd32768) begin
        out_q.result_value <= 16'sh8000;
        out_q.saturated    <= 1'b1;
      end else begin
        out_q.result_value <= y_q[15:0];
        out_q.saturated    <= 1'b0;
      end
    end else if (cmd_i.hist_ld) begin
      out_q.result_kind  <= RESULT_HIST;
      out_q.saturated    <= 1'b0;
      out_q.last         <= cmd_i.last;
      out_q.result_value <= h_eff[cmd_i.idx];
    end
  end

endmodule

[rtl/core/depthwise_causal_conv_with_state.sv]
`timescale 1ns / 1ps
// Depthwise causal convolution over 64 channels with per-channel history, bias and optional
// SiLU. One transaction is handled at a time: a sample passes the read, multiply and sum
// states, the sigmoid interpolation and product states when SiLU is enabled, then the final
// and output states; loads use the read state; a history read sends each word through a
// hold and an output state. Configuration writes are always accepted and take effect at once,
// so the user must issue them only while no transaction is in flight; the block does not check.
module depthwise_causal_conv_with_state import dcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [2:0] cfg_data_i
);

  dcc_cmd_t    cmd;
  dcc_status_t status;

  assign cfg_ready_o = 1'b1;

  dcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dcc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while a result is pending");

  a_conv_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.result_kind == RESULT_CONV) |-> out_item_o.last)
    else $error("convolution result not flagged last");

  a_hist_unsat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.saturated) |-> out_item_o.result_kind == RESULT_CONV)
    else $error("history word flagged saturated");

endmodule

[sim/depthwise_causal_conv_with_state_tb.sv]
`timescale 1ns / 1ps
module depthwise_causal_conv_with_state_tb;
  import dcc_pkg::*;

  localparam int IdleLimit  = 20000;
  localparam int HoldCycles = 200;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [2:0] cfg_data = '0;

  logic signed [15:0] weights [Channels*MaxTaps];
  bit                 weight_loaded [Channels*MaxTaps];
  logic signed [15:0] biases [Channels];
  logic signed [15:0] history [Channels*HistPerCh];
  bit                 silu_on;
  logic [2:0]         taps_reg;

  out_item_t expected_results[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_count = 0;
  bit  hold_off = 1'b0;

  depthwise_causal_conv_with_state uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int active_taps();
    int k;
    k = taps_reg;
    if (k < 1) k = 1;
    if (k > MaxTaps) k = MaxTaps;
    return k;
  endfunction

  function automatic longint floor_div(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint silu_value(longint x);
    logic [15:0] sig_tab [17] = '{16384, 20397, 23955, 26790, 28862, 30282, 31214,
      31807, 32179, 32408, 32549, 32635, 32687, 32719, 32738, 32750, 32757};
    longint a, s, idx, frac;
    if (x >= 32768) return x;
    if (x <= -32768) return 0;
    a = (x < 0) ? -x : x;
    idx = a >> 11;
    frac = a & 2047;
    s = sig_tab[idx] + (((sig_tab[idx+1] - sig_tab[idx]) * frac + 1024) >> 11);
    if (x < 0) s = 32768 - s;
    return floor_div(x * s + 16384, 15);
  endfunction

  task automatic predict_outputs(in_item_t it);
    int k, base;
    longint acc, y, xv;
    out_item_t r;
    k = active_taps();
    base = it.channel * HistPerCh;
    case (it.kind)
      KIND_SAMPLE: begin
        acc = longint'(biases[it.channel]) * 16384;
        for (int j = 0; j < k; j++) begin
          xv = (j + 1 < k) ? longint'(history[base+j]) : longint'(it.value);
          acc += xv * longint'(weights[it.channel*MaxTaps+j]);
        end
        y = floor_div(acc + 8192, 14);
        if (silu_on) y = silu_value(y);
        r = '0;
        if (y > 32767) begin
          y = 32767;
          r.saturated = 1'b1;
        end
        if (y < -32768) begin
          y = -32768;
          r.saturated = 1'b1;
        end
        for (int j = 0; j + 2 < k; j++) history[base+j] = history[base+j+1];
        if (k >= 2) history[base+k-2] = it.value;
        r.result_value = y[15:0];
        r.result_kind = RESULT_CONV;
        r.last = 1'b1;
        expected_results.push_back(r);
      end
      KIND_WEIGHT: begin
        weights[it.channel*MaxTaps+it.tap] = it.value;
        weight_loaded[it.channel*MaxTaps+it.tap] = 1'b1;
      end
      KIND_BIAS: biases[it.channel] = it.value;
      KIND_HIST_WR: if (it.tap < HistPerCh) history[base+it.tap] = it.value;
      KIND_HIST_RD: begin
        for (int s = 0; s < k - 1; s++) begin
          r.result_value = history[base+s];
          r.result_kind = RESULT_HIST;
          r.saturated = 1'b0;
          r.last = (s == k - 2);
          expected_results.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_outputs(it);
  endtask

  task automatic send_fields(logic [2:0] kind, int ch, int tap, int value);
    in_item_t it;
    it.kind = kind;
    it.channel = ChW'(ch);
    it.tap = TapW'(tap);
    it.value = 16'(value);
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_config(logic [1:0] idx, logic [2:0] data);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_ACT_EN) silu_on = data[0];
    else taps_reg = data;
    @(posedge clk);
  endtask

  // Any weight that a sample may read is loaded before use.
  function automatic bit kernel_ready(int ch);
    for (int j = 0; j < MaxTaps; j++)
      if (!weight_loaded[ch*MaxTaps+j]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic load_channel(int ch, bit big);
    for (int j = 0; j < MaxTaps; j++)
      send_fields(KIND_WEIGHT, ch, j, big ? $urandom : $urandom_range(0, 8000) - 4000);
    send_fields(KIND_BIAS, ch, 0, big ? $urandom : $urandom_range(0, 8000) - 4000);
  endtask

  task automatic send_random_item();
    int ch, sel;
    in_item_t it;
    ch = $urandom_range(0, 7);
    if ($urandom_range(9) == 0) ch = $urandom_range(0, Channels - 1);
    if (!kernel_ready(ch)) load_channel(ch, $urandom_range(3) == 0);
    sel = $urandom_range(99);
    it = in_item_t'($urandom);
    it.channel = ChW'(ch);
    if (sel < 60) it.kind = KIND_SAMPLE;
    else if (sel < 68) it.kind = KIND_WEIGHT;
    else if (sel < 74) it.kind = KIND_BIAS;
    else if (sel < 82) it.kind = KIND_HIST_WR;
    else if (sel < 94) it.kind = KIND_HIST_RD;
    else it.kind = 3'd5 + 3'($urandom_range(2));
    if (it.kind == KIND_SAMPLE && $urandom_range(1))
      it.value = 16'($urandom_range(0, 4000) - 2000);
    send_item(it);
  endtask

  task automatic test_directed();
    load_channel(0, 1'b0);
    send_fields(KIND_WEIGHT, 1, 0, 16'h7fff);
    send_fields(KIND_WEIGHT, 1, 1, 16'h7fff);
    send_fields(KIND_WEIGHT, 1, 2, 16'h7fff);
    send_fields(KIND_WEIGHT, 1, 3, 16'h7fff);
    send_fields(KIND_BIAS, 1, 0, 16'h7fff);
    send_fields(KIND_SAMPLE, 1, 0, 16'h7fff);
    send_fields(KIND_SAMPLE, 1, 3, 16'h7fff);
    send_fields(KIND_BIAS, 1, 0, 16'h8000);
    send_fields(KIND_WEIGHT, 1, 3, 16'h8000);
    send_fields(KIND_SAMPLE, 1, 0, 16'h7fff);
    send_fields(KIND_HIST_WR, 0, 0, 16'h8000);
    send_fields(KIND_HIST_WR, 0, 2, 16'h7fff);
    send_fields(KIND_HIST_WR, 0, 3, 16'h1234);
    send_fields(KIND_HIST_RD, 0, 0, 0);
    send_fields(KIND_SAMPLE, 0, 0, 16'h0800);
    send_fields(KIND_HIST_RD, 63, 0, 0);
    send_fields(3'd5, 0, 0, 16'hffff);
    send_fields(3'd7, 63, 3, 16'h8000);
    send_fields(KIND_SAMPLE, 0, 0, 16'h0000);
    wait_drained();
  endtask

  task automatic test_settings();
    logic [2:0] taps_seq [6] = '{3'd1, 3'd2, 3'd0, 3'd7, 3'd3, 3'd4};
    foreach (taps_seq[i]) begin
      write_config(CFG_TAPS, taps_seq[i]);
      write_config(CFG_ACT_EN, 3'(i % 2));
      for (int n = 0; n < 8; n++) send_random_item();
      wait_drained();
    end
  endtask

  task automatic test_silu_range();
    write_config(CFG_ACT_EN, 3'd1);
    write_config(CFG_TAPS, 3'd1);
    send_fields(KIND_WEIGHT, 2, 0, 16'h4000);
    send_fields(KIND_BIAS, 2, 0, 0);
    for (int v = -36000; v <= 36000; v += 3000) begin
      send_fields(KIND_SAMPLE, 2, 0, (v > 32767) ? 32767 : (v < -32768 ? -32768 : v));
    end
    wait_drained();
    write_config(CFG_TAPS, 3'd4);
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int n = 0; n < 12; n++) send_fields(KIND_HIST_RD, 0, 0, 0);
    hold_off = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 17 : (phase == 1 ? 77 : 0);
      recv_idle_pct = (phase == 0) ? 77 : (phase == 1 ? 17 : 0);
      write_config(CFG_ACT_EN, 3'($urandom_range(1)));
      write_config(CFG_TAPS, 3'($urandom_range(1, 4)));
      for (int n = 0; n < 28; n++) send_random_item();
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (hold_off && hold_count < HoldCycles) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else if (recv_idle_pct > 0) begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", out_item);
      end else begin
        want = expected_results.pop_front();
        if (out_item !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, out_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    silu_on = 1'b0;
    taps_reg = 3'd4;
    foreach (biases[i]) biases[i] = '0;
    foreach (history[i]) history[i] = '0;
    foreach (weights[i]) begin
      weights[i] = '0;
      weight_loaded[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 17;
    recv_idle_pct = 77;
    test_directed();
    test_settings();
    test_silu_range();
    test_backpressure();
    test_random_mix();
    wait_drained();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[depthwise_causal_conv_with_state.f]
rtl/core/dcc_pkg.sv
rtl/core/dcc_ctrl.sv
rtl/core/dcc_datapath.sv
rtl/core/depthwise_causal_conv_with_state.sv
sim/depthwise_causal_conv_with_state_tb.sv
